[hdl/hst_pkg.sv]
// ----------------------------------------------------------------------------
// hst_pkg: shared types and constants for the handle slot table
//
// Operation codes, controller states and field widths used by the table.
// ----------------------------------------------------------------------------
`default_nettype none

package hst_pkg;

  // Default slot count of the table
  localparam int SLOTS_DEF = 16;

  // Fixed field widths
  localparam int HANDLE_W  = 32;
  localparam int PAYLOAD_W = 32;
  localparam int COUNT_W   = 5;

  // Operation codes carried on op
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FIND_RD,
    ST_FIND_DONE,
    ST_LIST_SCAN,
    ST_LIST_EMIT
  } state_t;

endpackage

`default_nettype wire

[hdl/handle_slot_table.sv]
// ----------------------------------------------------------------------------
// handle_slot_table: fixed slot table that issues nonzero handles
//
// Allocates handles from a wrapping issue counter, looks up and deletes
// entries by handle, and lists live handles in slot order.
//
//   channel   direction  ports                                   handshake
//   command   in         op handle_in payload list_limit         start & !busy
//   result    out        ok handle_out payload_out occupancy last  result_valid
//   config    in         cfg_wdata                               cfg_we
//
// Steps from the accepted command to its result strobe: look up and delete run
// the reciprocal multiply, the memory read and the compare; allocate steps the
// counter until the slot of the candidate handle is free, or is refused; a list
// scans slot by slot and strobes once per handle emitted, once if it is empty.
// busy drops in the cycle of the last strobe, so the next command is accepted at
// the edge that ends it. Reset is synchronous and clears the slot valid bits at
// once. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_slot_table #(
  parameter int SLOTS = hst_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // command transaction
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [hst_pkg::HANDLE_W-1:0]   handle_in,
  input  logic [hst_pkg::PAYLOAD_W-1:0]  payload,
  input  logic [hst_pkg::COUNT_W-1:0]    list_limit,
  // result transaction
  output logic                           result_valid,
  output logic                           ok,
  output logic [hst_pkg::HANDLE_W-1:0]   handle_out,
  output logic [hst_pkg::PAYLOAD_W-1:0]  payload_out,
  output logic [hst_pkg::COUNT_W-1:0]    occupancy,
  output logic                           last,
  // configuration
  input  logic                           cfg_we,
  input  logic [hst_pkg::COUNT_W-1:0]    cfg_wdata
);

  import hst_pkg::*;

  // Derived sizes
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LIVE_W  = $clog2(SLOTS + 1);
  localparam int CMP_W   = (LIVE_W > COUNT_W) ? LIVE_W : COUNT_W;
  localparam int PROD_W  = 2 * HANDLE_W + 1;
  localparam int QSHIFT  = HANDLE_W + SLOT_W;

  // Reciprocal for handle modulo SLOTS: ceil(2^(32+L) / SLOTS), L = ceil(log2)
  localparam logic [63:0] MAGIC_WIDE =
    ((64'd1 << QSHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [HANDLE_W:0] MAGIC = MAGIC_WIDE[HANDLE_W:0];

  localparam logic [SLOT_W-1:0] SLOTS_LO   = SLOT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);
  localparam logic [CMP_W-1:0]  SLOTS_CMP  = CMP_W'(SLOTS);
  localparam logic [CMP_W-1:0]  FILL_RESET = CMP_W'((SLOTS * 3) / 4);

  // Registers
  state_t                state;
  state_t                state_next;
  logic [CMP_W-1:0]      fill_limit;
  logic [LIVE_W-1:0]     live_count;
  logic [LIVE_W-1:0]     live_next;
  logic [HANDLE_W-1:0]   issue_ctr;
  logic [SLOT_W-1:0]     ctr_slot;
  logic [SLOTS-1:0]      slot_valid;
  op_t                   op_q;
  logic [HANDLE_W-1:0]   handle_q;
  logic [PAYLOAD_W-1:0]  payload_q;
  logic [COUNT_W-1:0]    limit_q;
  logic [PROD_W-1:0]     prod;
  logic [SLOT_W-1:0]     idx;
  logic [COUNT_W-1:0]    list_n;
  logic                  list_fin;
  logic                  rd_hit;
  logic [HANDLE_W-1:0]   rd_handle;
  logic [PAYLOAD_W-1:0]  rd_payload;

  // Slot memories
  logic [HANDLE_W-1:0]   handle_mem  [SLOTS];
  logic [PAYLOAD_W-1:0]  payload_mem [SLOTS];

  // Combinational control
  logic                  accept;
  logic [HANDLE_W-1:0]   cand_handle;
  logic [SLOT_W-1:0]     cand_slot;
  logic                  cand_free;
  logic                  alloc_refuse;
  logic [SLOT_W-1:0]     find_slot;
  logic [SLOT_W-1:0]     mult_lo;
  logic                  find_match;
  logic                  list_empty;
  logic [SLOTS-1:0]      hi_mask;
  logic                  fin_calc;
  logic [CMP_W-1:0]      live_ext;

  logic                  rd_en;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  mem_we;
  logic                  ctr_step;
  logic                  valid_set;
  logic                  valid_clr;
  logic                  idx_step;
  logic                  idx_load;
  logic                  fin_load;
  logic                  emit;
  logic                  e_ok;
  logic [HANDLE_W-1:0]   e_handle;
  logic [PAYLOAD_W-1:0]  e_payload;
  logic                  e_last;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Next counter value, skipping zero, and its slot tracked incrementally
  always_comb begin
    if (issue_ctr == '1) begin
      cand_handle = HANDLE_W'(1);
      cand_slot   = SLOT_W'(1);
    end else begin
      cand_handle = issue_ctr + HANDLE_W'(1);
      cand_slot   = (ctr_slot == LAST_SLOT) ? '0 : ctr_slot + SLOT_W'(1);
    end
  end

  assign cand_free    = !slot_valid[cand_slot];
  assign live_ext     = CMP_W'(live_count);
  assign alloc_refuse = (payload_q == '0) || (live_ext >= SLOTS_CMP) ||
                        (live_ext >= fill_limit);

  // Handle modulo SLOTS: remainder from the registered reciprocal product
  assign mult_lo   = prod[QSHIFT +: SLOT_W] * SLOTS_LO;
  assign find_slot = handle_q[SLOT_W-1:0] - mult_lo;

  assign find_match = rd_hit && (handle_q != '0) && (rd_handle == handle_q);

  // List end detection: limit reached or no live slot above the current one
  assign list_empty = (limit_q == '0) || (slot_valid == '0);
  assign hi_mask    = ~(((SLOTS'(1) << idx) << 1) - SLOTS'(1));
  assign fin_calc   = (COUNT_W'(list_n + COUNT_W'(1)) == limit_q) ||
                      ((slot_valid & hi_mask) == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(op))
            OP_ALLOC:               state_next = ST_ALLOC;
            OP_LOOKUP, OP_DELETE:   state_next = ST_FIND_RD;
            OP_LIST:                state_next = ST_LIST_SCAN;
          endcase
        end
      end
      ST_ALLOC: begin
        if (alloc_refuse || cand_free) state_next = ST_IDLE;
      end
      ST_FIND_RD:   state_next = ST_FIND_DONE;
      ST_FIND_DONE: state_next = ST_IDLE;
      ST_LIST_SCAN: begin
        priority if (list_n == '0 && list_empty) state_next = ST_IDLE;
        else if (slot_valid[idx])                state_next = ST_LIST_EMIT;
      end
      ST_LIST_EMIT: begin
        state_next = list_fin ? ST_IDLE : ST_LIST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control and result selection
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = idx;
    mem_we    = 1'b0;
    ctr_step  = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    idx_step  = 1'b0;
    idx_load  = 1'b0;
    fin_load  = 1'b0;
    live_next = live_count;
    emit      = 1'b0;
    e_ok      = 1'b0;
    e_handle  = '0;
    e_payload = '0;
    e_last    = 1'b1;
    unique case (state)
      ST_IDLE: ;
      ST_ALLOC: begin
        if (alloc_refuse) begin
          emit = 1'b1;
        end else begin
          ctr_step = 1'b1;
          if (cand_free) begin
            mem_we    = 1'b1;
            valid_set = 1'b1;
            live_next = live_count + LIVE_W'(1);
            emit      = 1'b1;
            e_ok      = 1'b1;
            e_handle  = cand_handle;
          end
        end
      end
      ST_FIND_RD: begin
        rd_en    = 1'b1;
        rd_addr  = find_slot;
        idx_load = 1'b1;
      end
      ST_FIND_DONE: begin
        emit = 1'b1;
        if (find_match) begin
          e_ok      = 1'b1;
          e_payload = rd_payload;
          if (op_q == OP_DELETE) begin
            valid_clr = 1'b1;
            live_next = live_count - LIVE_W'(1);
          end
        end
      end
      ST_LIST_SCAN: begin
        priority if (list_n == '0 && list_empty) begin
          emit = 1'b1;
        end else if (slot_valid[idx]) begin
          rd_en    = 1'b1;
          fin_load = 1'b1;
        end else begin
          idx_step = 1'b1;
        end
      end
      ST_LIST_EMIT: begin
        emit     = 1'b1;
        e_ok     = 1'b1;
        e_handle = rd_handle;
        e_last   = list_fin;
        idx_step = !list_fin;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_limit   <= FILL_RESET;
      live_count   <= '0;
      issue_ctr    <= '0;
      ctr_slot     <= '0;
      slot_valid   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      live_count   <= live_next;
      result_valid <= emit;
      if (cfg_we) fill_limit <= CMP_W'(cfg_wdata);
      if (ctr_step) begin
        issue_ctr <= cand_handle;
        ctr_slot  <= cand_slot;
      end
      if (valid_set) slot_valid[cand_slot] <= 1'b1;
      if (valid_clr) slot_valid[idx]       <= 1'b0;
    end
  end

  // Capture the command and start the modulo multiply
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op_t'(op);
      handle_q  <= handle_in;
      payload_q <= payload;
      limit_q   <= list_limit;
      prod      <= {{(HANDLE_W + 1){1'b0}}, handle_in} *
                   {{HANDLE_W{1'b0}}, MAGIC};
    end
  end

  // Slot index and list progress
  always_ff @(posedge clk) begin
    if (accept) begin
      idx    <= '0;
      list_n <= '0;
    end else if (idx_load) begin
      idx    <= find_slot;
      rd_hit <= slot_valid[find_slot];
    end else if (idx_step) begin
      idx <= idx + SLOT_W'(1);
      if (state == ST_LIST_EMIT) list_n <= list_n + COUNT_W'(1);
    end
    if (fin_load) list_fin <= fin_calc;
  end

  // Slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      handle_mem[cand_slot]  <= cand_handle;
      payload_mem[cand_slot] <= payload_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_handle  <= handle_mem[rd_addr];
      rd_payload <= payload_mem[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit) begin
      ok          <= e_ok;
      handle_out  <= e_handle;
      payload_out <= e_payload;
      occupancy   <= COUNT_W'(live_next);
      last        <= e_last;
    end
  end

`ifndef SYNTH
  // Occupancy count tracks the live slots
  a_live_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == int'(live_count))
    else $error("live count differs from number of live slots");

  // Occupancy never exceeds the table size
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= LIVE_W'(SLOTS))
    else $error("live count above slot count");

  // An accepted command always sets the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted without going busy");

  // A successful result that is not a payload carries a nonzero handle
  a_ok_handle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ok && payload_out == '0 && handle_out == '0) |->
      $past(state) == ST_FIND_DONE)
    else $error("successful allocate or list result with zero handle");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the handle slot table
//
// Commands go to the block from a queue of pending items that the stimulus
// process keeps filled. A clocked driver presents them at the falling edge.
// A clocked monitor samples at the rising edge. On each accepted command it
// steps a shadow copy of the table and queues the results the block owes.
// It then compares every result strobe, field by field, against the oldest
// owed result. The stimulus starts with a directed sequence and then runs
// random phases, one for each fill limit setting.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import hst_pkg::*;

  localparam int SLOTS         = SLOTS_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 3000;
  localparam int TAIL_CYCLES   = 60;

  typedef enum logic [1:0] {
    ITEM_CMD,
    ITEM_CFG,
    ITEM_DRAIN
  } item_kind_t;

  typedef enum logic {
    DRV_FETCH,
    DRV_WAIT_ACC
  } drv_state_t;

  typedef struct {
    item_kind_t           kind;
    op_t                  code;
    logic [HANDLE_W-1:0]  handle;
    logic [PAYLOAD_W-1:0] pay;
    logic [COUNT_W-1:0]   lim;
    logic [COUNT_W-1:0]   fill;
    int                   gap;
  } table_item_t;

  typedef struct {
    logic                 ok;
    logic [HANDLE_W-1:0]  handle;
    logic [PAYLOAD_W-1:0] pay;
    logic [COUNT_W-1:0]   occ;
    logic                 last;
  } table_result_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 start       = 1'b0;
  logic                 busy;
  op_t                  op          = OP_ALLOC;
  logic [HANDLE_W-1:0]  handle_in   = '0;
  logic [PAYLOAD_W-1:0] payload     = '0;
  logic [COUNT_W-1:0]   list_limit  = '0;
  logic                 result_valid;
  logic                 ok;
  logic [HANDLE_W-1:0]  handle_out;
  logic [PAYLOAD_W-1:0] payload_out;
  logic [COUNT_W-1:0]   occupancy;
  logic                 last;
  logic                 cfg_we      = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata   = '0;

  // Shadow copy of the table state
  logic [HANDLE_W-1:0]  tbl_handle [SLOTS];
  logic [PAYLOAD_W-1:0] tbl_payload [SLOTS];
  logic [COUNT_W-1:0]   tbl_live;
  logic [HANDLE_W-1:0]  tbl_counter;
  logic [COUNT_W-1:0]   tbl_fill_limit;

  table_item_t   cmd_queue [$];
  table_result_t owed_results [$];

  logic       cmd_taken = 1'b0;
  drv_state_t drv_state = DRV_FETCH;
  int         wait_cnt  = 0;
  int         burst_left = 0;
  int         err_count = 0;
  int         idle_cycles = 0;

  handle_slot_table dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .handle_in    (handle_in),
    .payload      (payload),
    .list_limit   (list_limit),
    .result_valid (result_valid),
    .ok           (ok),
    .handle_out   (handle_out),
    .payload_out  (payload_out),
    .occupancy    (occupancy),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Hold reset from time zero, then release it at a falling edge
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Queue one owed result, tagged with the current occupancy
  task automatic owe_result(input logic rok, input logic [HANDLE_W-1:0] rh,
                            input logic [PAYLOAD_W-1:0] rp, input logic rlast);
    table_result_t r;
    r.ok     = rok;
    r.handle = rh;
    r.pay    = rp;
    r.occ    = tbl_live;
    r.last   = rlast;
    owed_results.push_back(r);
  endtask

  // Step the shadow table by one command and queue the results it causes
  task automatic slot_table_step(input op_t code, input logic [HANDLE_W-1:0] h,
                                 input logic [PAYLOAD_W-1:0] pay,
                                 input logic [COUNT_W-1:0] lim);
    logic [HANDLE_W-1:0]  cand;
    logic [HANDLE_W-1:0]  listed [SLOTS];
    logic [PAYLOAD_W-1:0] found;
    logic [COUNT_W-1:0]   cap;
    logic                 placed;
    int                   s;
    int                   n;
    int                   step;
    cap = (tbl_fill_limit > SLOTS) ? COUNT_W'(SLOTS) : tbl_fill_limit;
    cand = '0;
    case (code)
      OP_ALLOC: begin
        // Advance the counter, skipping zero, until a free slot turns up
        placed = 1'b0;
        if (pay != '0 && tbl_live < cap) begin
          for (step = 0; step < 2 * SLOTS + 2 && !placed; step++) begin
            cand = tbl_counter + 1;
            if (cand == '0) cand = 1;
            tbl_counter = cand;
            s = int'(cand % SLOTS);
            if (tbl_handle[s] == '0) begin
              tbl_handle[s]  = cand;
              tbl_payload[s] = pay;
              tbl_live++;
              placed = 1'b1;
            end
          end
        end
        owe_result(placed, placed ? cand : '0, '0, 1'b1);
      end
      OP_LOOKUP, OP_DELETE: begin
        s = int'(h % SLOTS);
        if (h != '0 && tbl_live != '0 && tbl_handle[s] == h) begin
          found = tbl_payload[s];
          if (code == OP_DELETE) begin
            tbl_handle[s]  = '0;
            tbl_payload[s] = '0;
            tbl_live--;
          end
          owe_result(1'b1, '0, found, 1'b1);
        end else begin
          owe_result(1'b0, '0, '0, 1'b1);
        end
      end
      default: begin
        // Collect live handles in slot order up to the limit
        n = 0;
        for (s = 0; s < SLOTS; s++) begin
          if (n < lim && tbl_handle[s] != '0) begin
            listed[n] = tbl_handle[s];
            n++;
          end
        end
        if (n == 0) begin
          owe_result(1'b0, '0, '0, 1'b1);
        end else begin
          for (s = 0; s < n; s++) owe_result(1'b1, listed[s], '0, s == n - 1);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      err_count++;
    end
  endtask

  // Monitor: track accepted transactions and check result strobes
  always @(posedge clk) begin : monitor
    table_result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < SLOTS; i++) begin
        tbl_handle[i]  = '0;
        tbl_payload[i] = '0;
      end
      tbl_live       = '0;
      tbl_counter    = '0;
      tbl_fill_limit = COUNT_W'((SLOTS * 3) / 4);
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= start && !busy;
      if (cfg_we) tbl_fill_limit = cfg_wdata;
      if (start && !busy) slot_table_step(op, handle_in, payload, list_limit);
      if (result_valid) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: ok=%0d handle_out=%h payload_out=%h",
                 ok, handle_out, payload_out);
          err_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("ok", 32'(want.ok), 32'(ok));
          check_field("handle_out", want.handle, handle_out);
          check_field("payload_out", want.pay, payload_out);
          check_field("occupancy", 32'(want.occ), 32'(occupancy));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
    end
  end

  task automatic present_cmd(input table_item_t it);
    op         <= it.code;
    handle_in  <= it.handle;
    payload    <= it.pay;
    list_limit <= it.lim;
  endtask

  // Driver: present pending items at the falling edge
  always @(negedge clk) begin : driver
    table_item_t head;
    logic        n_start;
    logic        n_we;
    n_start = start;
    n_we    = 1'b0;
    if (!rst) begin
      case (drv_state)
        DRV_FETCH: begin
          if (cmd_queue.size() != 0) begin
            head = cmd_queue[0];
            if (head.kind == ITEM_CMD) begin
              if (wait_cnt >= head.gap) begin
                present_cmd(head);
                n_start   = 1'b1;
                wait_cnt  = 0;
                drv_state = DRV_WAIT_ACC;
              end else begin
                wait_cnt++;
              end
            end else if (owed_results.size() != 0 || busy) begin
              wait_cnt = 0;
            end else if (wait_cnt >= SETTLE_CYCLES) begin
              // Block is idle: write the register or release the pause
              if (head.kind == ITEM_CFG) begin
                n_we = 1'b1;
                cfg_wdata <= head.fill;
              end
              void'(cmd_queue.pop_front());
              wait_cnt = 0;
            end else begin
              wait_cnt++;
            end
          end
        end
        DRV_WAIT_ACC: begin
          if (cmd_taken) begin
            void'(cmd_queue.pop_front());
            // Keep start high when the next command follows with no gap
            if (cmd_queue.size() != 0 && cmd_queue[0].kind == ITEM_CMD &&
                cmd_queue[0].gap == 0) begin
              present_cmd(cmd_queue[0]);
            end else begin
              n_start   = 1'b0;
              drv_state = DRV_FETCH;
            end
          end
        end
        default: drv_state = DRV_FETCH;
      endcase
    end
    start  <= n_start;
    cfg_we <= n_we;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Draw the wait before a command, with occasional back-to-back bursts
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(8, 20);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic push_item(input table_item_t it);
    while (cmd_queue.size() >= 3) @(posedge clk);
    cmd_queue.push_back(it);
  endtask

  task automatic push_cmd(input op_t code, input logic [HANDLE_W-1:0] h,
                          input logic [PAYLOAD_W-1:0] pay,
                          input logic [COUNT_W-1:0] lim);
    table_item_t it;
    it.kind   = ITEM_CMD;
    it.code   = code;
    it.handle = h;
    it.pay    = pay;
    it.lim    = lim;
    it.fill   = '0;
    it.gap    = draw_gap();
    push_item(it);
  endtask

  task automatic push_ctrl(input item_kind_t kind, input logic [COUNT_W-1:0] fill);
    table_item_t it;
    it.kind   = kind;
    it.code   = OP_ALLOC;
    it.handle = '0;
    it.pay    = '0;
    it.lim    = '0;
    it.fill   = fill;
    it.gap    = 0;
    push_item(it);
  endtask

  // Pick a handle to look up or delete, mostly a live one
  function automatic logic [HANDLE_W-1:0] pick_handle();
    logic [HANDLE_W-1:0] h;
    logic [HANDLE_W-1:0] live;
    int                  base;
    int                  k;
    int                  sel;
    base = $urandom_range(0, SLOTS - 1);
    live = '0;
    for (k = 0; k < SLOTS; k++) begin
      if (live == '0) live = tbl_handle[(base + k) % SLOTS];
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) h = '0;
    else if (sel == 1 || live == '0) h = $urandom;
    else if (sel == 2) h = live ^ (32'h1 << $urandom_range(0, 31));
    else h = live;
    return h;
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    logic [PAYLOAD_W-1:0] p;
    int                   sel;
    sel = $urandom_range(0, 24);
    p = $urandom;
    if (sel < 2) p = '0;
    else if (sel == 2) p = '1;
    else if (p == '0) p = 1;
    return p;
  endfunction

  // Queue one random command: mostly well formed, some noise
  task automatic push_random_cmd(input int alloc_pct);
    logic [HANDLE_W-1:0]  h;
    logic [PAYLOAD_W-1:0] p;
    logic [COUNT_W-1:0]   lim;
    int                   roll;
    h    = $urandom;
    p    = $urandom;
    lim  = COUNT_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      push_cmd(op_t'($urandom_range(0, 3)), h, p, lim);
    end else if (roll < 10 + alloc_pct) begin
      push_cmd(OP_ALLOC, h, pick_payload(), lim);
    end else begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 4) != 0) lim = COUNT_W'($urandom_range(0, 17));
      if (roll < 45) push_cmd(OP_LOOKUP, pick_handle(), p, lim);
      else if (roll < 80) push_cmd(OP_DELETE, pick_handle(), p, lim);
      else push_cmd(OP_LIST, h, p, lim);
    end
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    logic [COUNT_W-1:0] fills [7];
    int                 ph;
    int                 i;
    int                 pause_at;

    // Directed: empty table, refused and accepted allocations, hits, misses
    push_cmd(OP_LIST, '0, '0, 5'd16);
    push_cmd(OP_LOOKUP, '0, '0, '0);
    push_cmd(OP_LOOKUP, 32'd1, '0, '0);
    push_cmd(OP_ALLOC, '1, '0, '1);
    push_cmd(OP_ALLOC, '0, '1, '0);
    push_cmd(OP_ALLOC, '0, 32'd1, '0);
    push_cmd(OP_LOOKUP, 32'd1, '0, '0);
    push_cmd(OP_LOOKUP, '0, '0, '0);
    push_cmd(OP_LOOKUP, 32'd17, '0, '0);
    push_cmd(OP_LOOKUP, '1, '1, '1);
    push_cmd(OP_DELETE, 32'd2, '0, '0);
    push_cmd(OP_DELETE, 32'd2, '0, '0);
    push_cmd(OP_LIST, '0, '0, '0);
    push_cmd(OP_LIST, '1, '1, '1);
    // Fill up to the reset fill limit and one past it
    for (i = 0; i < 12; i++) push_cmd(OP_ALLOC, $urandom, pick_payload() | 32'h1, '0);
    push_cmd(OP_LIST, '0, '0, 5'd1);
    push_cmd(OP_LIST, '0, '0, 5'd16);

    // Random phases, one per fill limit setting
    fills = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd12, COUNT_W'($urandom_range(2, 15)), 5'd16};
    for (ph = 0; ph < 7; ph++) begin
      push_ctrl(ITEM_CFG, fills[ph]);
      if (fills[ph] >= SLOTS) begin
        for (i = 0; i < 18; i++) push_cmd(OP_ALLOC, $urandom, pick_payload(), '0);
      end
      pause_at = (ph == 0 || $urandom_range(0, 1) != 0) ? $urandom_range(0, 27) : -1;
      for (i = 0; i < 28; i++) begin
        if (i == pause_at) push_ctrl(ITEM_DRAIN, '0);
        push_random_cmd($urandom_range(25, 60));
      end
    end

    // Wait for everything to be accepted and every owed result to arrive
    while (cmd_queue.size() != 0 || start || owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
